// File: design/cpm_pkg.sv
// shared types and constants for the cycle power and rms meter
package cpm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SCALE   = 3'd5;

  localparam logic [15:0] RST_VOLTAGE_OFFSET = 16'd27525;
  localparam logic [15:0] RST_CURRENT_OFFSET = 16'd27525;
  localparam logic [23:0] RST_VOLTAGE_GAIN   = 24'd5888410;
  localparam logic [23:0] RST_CURRENT_GAIN   = 24'd229837;
  localparam logic [31:0] RST_INTEGRAL_SCALE = 32'd3579139;
  localparam logic [31:0] RST_ENERGY_SCALE   = 32'd1431655;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned POINT_W  = 26;

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_RD, S_LD, S_PE, S_PO, S_XR, S_LAST, S_PL, S_D1, S_D2,
    S_SL, S_SH, S_SS, S_PW, S_EM, S_EA, S_QS, S_QT, S_QE, S_DONE
  } cpm_state_t;

  typedef enum logic [1:0] {LD_PLAIN, LD_FIRST, LD_RIGHT} cpm_ld_t;
  typedef enum logic [1:0] {WT_1, WT_2, WT_4} cpm_wt_t;
  typedef enum logic [1:0] {SEL_P, SEL_V, SEL_I} cpm_sel_t;

  typedef enum logic [3:0] {
    FIN_NONE, FIN_SM_LO, FIN_SM_HI, FIN_SM_SUM, FIN_PWR, FIN_EN_MUL, FIN_EN_ACC,
    FIN_SQ_START, FIN_SQ_STEP, FIN_SQ_END
  } cpm_fin_t;

  typedef struct packed {
    logic     conv_mul;
    logic     ram_we;
    logic     clr;
    logic     ld;
    cpm_ld_t  ld_mode;
    logic     pt;
    logic     pt_odd;
    cpm_wt_t  pt_wt;
    cpm_fin_t fin;
    cpm_sel_t sel;
    logic     out_ld;
  } cpm_cmd_t;

  typedef struct packed {
    logic sq_last;
  } cpm_status_t;

endpackage

// File: design/cpm_ram.sv
// generic single write, single read ram with registered read data
module cpm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: design/cpm_ctrl.sv
// sequencer for sample capture, the end of cycle walk and the final arithmetic
module cpm_ctrl #(
  parameter int unsigned SAMPLES_PER_CYCLE = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_cycle_start,
  output logic                                 in_stall,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  input  cpm_pkg::cpm_status_t                 status,
  output cpm_pkg::cpm_cmd_t                    cmd,
  output logic [$clog2(SAMPLES_PER_CYCLE)-1:0] wr_addr,
  output logic [$clog2(SAMPLES_PER_CYCLE)-1:0] rd_addr
);
  import cpm_pkg::*;

  localparam int unsigned AW = $clog2(SAMPLES_PER_CYCLE);
  localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLES_PER_CYCLE - 1);
  localparam logic [AW-1:0] PENULT_K = AW'(SAMPLES_PER_CYCLE - 2);
  localparam logic [AW-1:0] XR_K     = AW'(SAMPLES_PER_CYCLE - 3);

  cpm_state_t    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  cpm_sel_t      sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      addr_r      <= '0;
      j_r         <= '0;
      k_r         <= '0;
      sel_r       <= SEL_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.ld_mode   = LD_PLAIN;
    cmd.pt_wt     = WT_2;
    cmd.fin       = FIN_NONE;
    cmd.sel       = sel_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.conv_mul = 1'b1;
          addr_nxt     = in_cycle_start ? '0 : cnt_r;
          state_nxt    = S_WR;
        end
      end
      S_WR: begin
        cmd.ram_we = 1'b1;
        if (addr_r == LAST_IDX) begin
          cnt_nxt   = '0;
          cmd.clr   = 1'b1;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_RD;
        end else begin
          cnt_nxt   = addr_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: state_nxt = S_LD;
      S_LD: begin
        cmd.ld      = 1'b1;
        cmd.ld_mode = (j_r == AW'(2)) ? LD_FIRST : LD_PLAIN;
        if (j_r < AW'(2)) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_PE;
        end
      end
      S_PE: begin
        cmd.pt    = 1'b1;
        cmd.pt_wt = (k_r == '0) ? WT_1 : WT_2;
        state_nxt = S_PO;
      end
      S_PO: begin
        cmd.pt     = 1'b1;
        cmd.pt_odd = 1'b1;
        cmd.pt_wt  = WT_4;
        k_nxt      = k_r + 1'b1;
        if (j_r != LAST_IDX) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD;
        end else if (k_r == XR_K) begin
          state_nxt = S_XR;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_XR: begin
        cmd.ld      = 1'b1;
        cmd.ld_mode = LD_RIGHT;
        state_nxt   = S_PE;
      end
      S_LAST: begin
        cmd.ld    = 1'b1;
        state_nxt = S_PL;
      end
      S_PL: begin
        cmd.pt    = 1'b1;
        cmd.pt_wt = WT_1;
        state_nxt = S_D1;
      end
      S_D1: state_nxt = S_D2;
      S_D2: begin
        sel_nxt   = SEL_P;
        state_nxt = S_SL;
      end
      S_SL: begin
        cmd.fin   = FIN_SM_LO;
        state_nxt = S_SH;
      end
      S_SH: begin
        cmd.fin   = FIN_SM_HI;
        state_nxt = S_SS;
      end
      S_SS: begin
        cmd.fin   = FIN_SM_SUM;
        state_nxt = (sel_r == SEL_P) ? S_PW : S_QS;
      end
      S_PW: begin
        cmd.fin   = FIN_PWR;
        state_nxt = S_EM;
      end
      S_EM: begin
        cmd.fin   = FIN_EN_MUL;
        state_nxt = S_EA;
      end
      S_EA: begin
        cmd.fin   = FIN_EN_ACC;
        sel_nxt   = SEL_V;
        state_nxt = S_SL;
      end
      S_QS: begin
        cmd.fin   = FIN_SQ_START;
        state_nxt = S_QT;
      end
      S_QT: begin
        cmd.fin = FIN_SQ_STEP;
        if (status.sq_last) begin
          state_nxt = S_QE;
        end
      end
      S_QE: begin
        cmd.fin = FIN_SQ_END;
        if (sel_r == SEL_V) begin
          sel_nxt   = SEL_I;
          state_nxt = S_SL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the previous result beat has gone
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign wr_addr   = addr_r;
  assign rd_addr   = j_r;
endmodule

// File: design/cpm_datapath.sv
// sample conversion, point window, weighted sums, scaling, root and energy
module cpm_datapath #(
  parameter int unsigned SAMPLES_PER_CYCLE = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cpm_pkg::cpm_cmd_t                    cmd,
  output cpm_pkg::cpm_status_t                 status,
  input  logic [$clog2(SAMPLES_PER_CYCLE)-1:0] wr_addr,
  input  logic [$clog2(SAMPLES_PER_CYCLE)-1:0] rd_addr,
  input  logic [9:0]                           in_voltage_code,
  input  logic [9:0]                           in_current_code,
  input  logic [15:0]                          voltage_offset,
  input  logic [15:0]                          current_offset,
  input  logic [23:0]                          voltage_gain,
  input  logic [23:0]                          current_gain,
  input  logic [31:0]                          integral_scale,
  input  logic [31:0]                          energy_scale,
  output logic signed [31:0]                   out_real_power,
  output logic [31:0]                          out_rms_voltage,
  output logic [31:0]                          out_peak_current,
  output logic signed [63:0]                   out_energy_total
);
  import cpm_pkg::*;

  // ---------------- conversion
  logic signed [16:0] dv_diff, di_diff;
  logic signed [41:0] dv_ext, di_ext, gv_ext, gi_ext;
  logic signed [41:0] cv_r, ci_r;
  logic signed [41:0] rv_rnd, ri_rnd;
  logic [SAMPLE_W-1:0] sv_w, si_w;

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [41:0] x);
    logic [SAMPLE_W-1:0] y;
    if (x > 42'sd8388607) y = 24'h7FFFFF;
    else if (x < -42'sd8388608) y = 24'h800000;
    else y = x[SAMPLE_W-1:0];
    return y;
  endfunction

  assign dv_diff = $signed({1'b0, in_voltage_code, 6'b0}) - $signed({1'b0, voltage_offset});
  assign di_diff = $signed({1'b0, in_current_code, 6'b0}) - $signed({1'b0, current_offset});
  assign dv_ext  = 42'(dv_diff);
  assign di_ext  = 42'(di_diff);
  assign gv_ext  = $signed({18'b0, voltage_gain});
  assign gi_ext  = $signed({18'b0, current_gain});
  assign rv_rnd  = (cv_r + 42'sd32768) >>> 16;
  assign ri_rnd  = (ci_r + 42'sd32768) >>> 16;
  assign sv_w    = sat_sample(rv_rnd);
  assign si_w    = sat_sample(ri_rnd);

  always_ff @(posedge clk) begin
    if (cmd.conv_mul) begin
      cv_r <= dv_ext * gv_ext;
      ci_r <= di_ext * gi_ext;
    end
  end

  logic [SAMPLE_W-1:0] rdv, rdi;

  cpm_ram #(.WIDTH(SAMPLE_W), .DEPTH(SAMPLES_PER_CYCLE)) u_vram (
    .clk(clk), .we(cmd.ram_we), .waddr(wr_addr), .wdata(sv_w),
    .raddr(rd_addr), .rdata(rdv)
  );
  cpm_ram #(.WIDTH(SAMPLE_W), .DEPTH(SAMPLES_PER_CYCLE)) u_iram (
    .clk(clk), .we(cmd.ram_we), .waddr(wr_addr), .wdata(si_w),
    .raddr(rd_addr), .rdata(rdi)
  );

  // ---------------- four point window per channel
  logic signed [POINT_W-1:0] wv_r [4];
  logic signed [POINT_W-1:0] wc_r [4];
  logic signed [POINT_W-1:0] xv, xc;

  assign xv = POINT_W'($signed(rdv));
  assign xc = POINT_W'($signed(rdi));

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      wv_r[1] <= wv_r[2];
      wv_r[2] <= wv_r[3];
      wc_r[1] <= wc_r[2];
      wc_r[2] <= wc_r[3];
      case (cmd.ld_mode)
        LD_FIRST: begin
          // left extrapolation from the first two samples
          wv_r[0] <= (wv_r[2] <<< 1) - wv_r[3];
          wc_r[0] <= (wc_r[2] <<< 1) - wc_r[3];
          wv_r[3] <= xv;
          wc_r[3] <= xc;
        end
        LD_RIGHT: begin
          wv_r[0] <= wv_r[1];
          wc_r[0] <= wc_r[1];
          wv_r[3] <= (wv_r[3] <<< 1) - wv_r[2];
          wc_r[3] <= (wc_r[3] <<< 1) - wc_r[2];
        end
        default: begin
          wv_r[0] <= wv_r[1];
          wc_r[0] <= wc_r[1];
          wv_r[3] <= xv;
          wc_r[3] <= xc;
        end
      endcase
    end
  end

  function automatic logic signed [POINT_W-1:0] midpt(
    input logic signed [POINT_W-1:0] a, input logic signed [POINT_W-1:0] b,
    input logic signed [POINT_W-1:0] c, input logic signed [POINT_W-1:0] d);
    logic signed [30:0] ea, eb, ec, ed, s;
    ea = 31'(a);
    eb = 31'(b);
    ec = 31'(c);
    ed = 31'(d);
    s  = (eb + ec) * 31'sd9 - ea - ed + 31'sd8;
    return POINT_W'(s >>> 4);
  endfunction

  // ---------------- point, product and accumulate stages
  logic signed [POINT_W-1:0] pv_r, pc_r;
  logic                      pt_vld_r, prod_vld_r;
  cpm_wt_t                   pt_w_r, prod_w_r;
  logic signed [51:0]        ppv_r, ppvv_r, ppcc_r;
  logic signed [51:0]        pve, pce;
  logic signed [63:0]        sp_r, sv_r, si_r;

  assign pve = 52'(pv_r);
  assign pce = 52'(pc_r);

  function automatic logic signed [63:0] weigh(input logic signed [51:0] p, input cpm_wt_t w);
    logic signed [63:0] e;
    logic signed [63:0] y;
    e = 64'(p);
    case (w)
      WT_1:    y = e;
      WT_4:    y = e <<< 2;
      default: y = e <<< 1;
    endcase
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.pt) begin
      pv_r   <= cmd.pt_odd ? midpt(wv_r[0], wv_r[1], wv_r[2], wv_r[3]) : wv_r[1];
      pc_r   <= cmd.pt_odd ? midpt(wc_r[0], wc_r[1], wc_r[2], wc_r[3]) : wc_r[1];
      pt_w_r <= cmd.pt_wt;
    end
    ppv_r    <= pve * pce;
    ppvv_r   <= pve * pve;
    ppcc_r   <= pce * pce;
    prod_w_r <= pt_w_r;
    if (cmd.clr) begin
      sp_r <= '0;
      sv_r <= '0;
      si_r <= '0;
    end else if (prod_vld_r) begin
      sp_r <= sp_r + weigh(ppv_r, prod_w_r);
      sv_r <= sv_r + weigh(ppvv_r, prod_w_r);
      si_r <= si_r + weigh(ppcc_r, prod_w_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      pt_vld_r   <= cmd.pt;
      prod_vld_r <= pt_vld_r;
    end
  end

  // ---------------- final arithmetic on one shared 32x32 multiplier
  logic [63:0]        sp_mag, fx;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mu_r;
  logic [31:0]        lohold_r;
  logic [63:0]        smr_r;
  logic [63:0]        q, inc;
  logic signed [31:0] power_r;
  logic signed [32:0] pw_ext;
  logic [31:0]        pmag;
  logic signed [63:0] energy_r;
  logic signed [64:0] esum;
  logic [63:0]        sq_x_r, sq_r_r, sq_b_r;
  logic [64:0]        sq_t;
  logic [63:0]        sq_res;
  logic [31:0]        rv_r, pk_r;

  assign sp_mag = sp_r[63] ? 64'(-sp_r) : 64'(sp_r);
  always_comb begin
    case (cmd.sel)
      SEL_V:   fx = 64'(sv_r);
      SEL_I:   fx = 64'(si_r);
      default: fx = sp_mag;
    endcase
  end

  assign pw_ext = 33'(power_r);
  assign pmag   = power_r[31] ? 32'(-pw_ext) : 32'(pw_ext);

  always_comb begin
    case (cmd.fin)
      FIN_SM_HI: begin
        mul_a = fx[63:32];
        mul_b = integral_scale;
      end
      FIN_EN_MUL: begin
        mul_a = pmag;
        mul_b = energy_scale;
      end
      default: begin
        mul_a = fx[31:0];
        mul_b = integral_scale;
      end
    endcase
  end

  assign q    = (smr_r + 64'd32768) >> 16;
  assign inc  = (mu_r + 64'd32768) >> 16;
  assign esum = power_r[31] ? ({energy_r[63], energy_r} - $signed({1'b0, inc}))
                            : ({energy_r[63], energy_r} + $signed({1'b0, inc}));
  assign sq_t   = {1'b0, sq_r_r} + {1'b0, sq_b_r};
  assign sq_res = sq_r_r + {63'b0, (sq_x_r > sq_r_r)};

  always_ff @(posedge clk) begin
    case (cmd.fin)
      FIN_SM_LO: mu_r <= 64'(mul_a) * 64'(mul_b);
      FIN_SM_HI: begin
        lohold_r <= mu_r[63:32];
        mu_r     <= 64'(mul_a) * 64'(mul_b);
      end
      FIN_SM_SUM: smr_r <= mu_r + {32'b0, lohold_r};
      FIN_PWR: begin
        if (sp_r[63]) begin
          power_r <= (q > 64'd2147483648) ? 32'sh80000000 : 32'(-q);
        end else begin
          power_r <= (q > 64'd2147483647) ? 32'sh7FFFFFFF : q[31:0];
        end
      end
      FIN_EN_MUL: mu_r <= 64'(mul_a) * 64'(mul_b);
      FIN_SQ_START: begin
        sq_x_r <= (cmd.sel == SEL_I) ? {smr_r[62:0], 1'b0} : smr_r;
        sq_r_r <= '0;
        sq_b_r <= 64'h4000_0000_0000_0000;
      end
      FIN_SQ_STEP: begin
        if ({1'b0, sq_x_r} >= sq_t) begin
          sq_x_r <= sq_x_r - sq_t[63:0];
          sq_r_r <= (sq_r_r >> 1) + sq_b_r;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
      end
      FIN_SQ_END: begin
        if (cmd.sel == SEL_I) pk_r <= sq_res[31:0];
        else rv_r <= sq_res[31:0];
      end
      default: ;
    endcase
  end

  // saturating energy accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
    end else if (cmd.fin == FIN_EN_ACC) begin
      if (esum[64] != esum[63]) begin
        energy_r <= esum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
        energy_r <= esum[63:0];
      end
    end
  end

  assign status.sq_last = sq_b_r[0];

  // ---------------- result beat registers
  logic signed [31:0] o_pw_r;
  logic [31:0]        o_rv_r, o_pk_r;
  logic signed [63:0] o_en_r;

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      o_pw_r <= power_r;
      o_rv_r <= rv_r;
      o_pk_r <= pk_r;
      o_en_r <= energy_r;
    end
  end

  assign out_real_power   = o_pw_r;
  assign out_rms_voltage  = o_rv_r;
  assign out_peak_current = o_pk_r;
  assign out_energy_total = o_en_r;
endmodule

// File: design/cycle_power_rms_meter.sv
// top level of the cycle power and rms meter
//
// Each input beat carries one voltage and one current ADC code and a
// cycle_start flag. A beat is taken when in_valid is high and in_stall low;
// each pair is converted and then stored, and no new beat is taken while it
// is being stored. The beat that completes SAMPLES_PER_CYCLE pairs starts
// the end of cycle walk: reads, window shifts and points for each sample,
// then the scaling steps and two 32-step square roots on one shared 32x32
// multiplier and one shared root unit.
// Input is stalled during the walk. The result beat then sits in an output
// register, held while out_stall is high; new pairs are accepted meanwhile,
// and only the next result waits for it to go.
// Configuration writes are taken on any cycle (cfg_ready is tied high);
// they should be made while the block is idle.
// Reset restores the default calibration, clears the sample count and the
// energy accumulator and drops out_valid. The sample rams are not cleared.
module cycle_power_rms_meter #(
  parameter int unsigned SAMPLES_PER_CYCLE = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [9:0]                         in_voltage_code,
  input  logic [9:0]                         in_current_code,
  input  logic                               in_cycle_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [31:0]                 out_real_power,
  output logic [31:0]                        out_rms_voltage,
  output logic [31:0]                        out_peak_current,
  output logic signed [63:0]                 out_energy_total,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cpm_pkg::*;

  localparam int unsigned AW = $clog2(SAMPLES_PER_CYCLE);

  logic [15:0] voltage_offset_r, current_offset_r;
  logic [23:0] voltage_gain_r, current_gain_r;
  logic [31:0] integral_scale_r, energy_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voltage_offset_r <= RST_VOLTAGE_OFFSET;
      current_offset_r <= RST_CURRENT_OFFSET;
      voltage_gain_r   <= RST_VOLTAGE_GAIN;
      current_gain_r   <= RST_CURRENT_GAIN;
      integral_scale_r <= RST_INTEGRAL_SCALE;
      energy_scale_r   <= RST_ENERGY_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VOLTAGE_OFFSET: voltage_offset_r <= cfg_data[15:0];
        CFG_CURRENT_OFFSET: current_offset_r <= cfg_data[15:0];
        CFG_VOLTAGE_GAIN:   voltage_gain_r   <= cfg_data[23:0];
        CFG_CURRENT_GAIN:   current_gain_r   <= cfg_data[23:0];
        CFG_INTEGRAL_SCALE: integral_scale_r <= cfg_data;
        CFG_ENERGY_SCALE:   energy_scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  cpm_cmd_t      cmd;
  cpm_status_t   status;
  logic [AW-1:0] wr_addr, rd_addr;

  cpm_ctrl #(.SAMPLES_PER_CYCLE(SAMPLES_PER_CYCLE)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_cycle_start(in_cycle_start), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr)
  );

  cpm_datapath #(.SAMPLES_PER_CYCLE(SAMPLES_PER_CYCLE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .wr_addr(wr_addr), .rd_addr(rd_addr),
    .in_voltage_code(in_voltage_code), .in_current_code(in_current_code),
    .voltage_offset(voltage_offset_r), .current_offset(current_offset_r),
    .voltage_gain(voltage_gain_r), .current_gain(current_gain_r),
    .integral_scale(integral_scale_r), .energy_scale(energy_scale_r),
    .out_real_power(out_real_power), .out_rms_voltage(out_rms_voltage),
    .out_peak_current(out_peak_current), .out_energy_total(out_energy_total)
  );

  // a pair beat is always followed by a busy cycle for its store write
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // a result beat only appears after the walk, never straight out of capture
  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while input was open");

  // a result beat held by out_stall is never dropped
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("held result beat lost");
endmodule
